// File: hdl/lgfs_pkg.sv
// Shared constants, register indexes and helpers for the line grep block.
// No dependencies; compiled first.
package lgfs_pkg;

    // defaults for the top-level parameters and the shown-length clip
    localparam int DEF_MAX_PATTERN   = 16;
    localparam int DEF_SHOW_LIMIT    = 300;
    localparam int DEF_POSITION_BITS = 22;

    // fixed field widths
    localparam int BYTE_W      = 8;
    localparam int SHOW_W      = 9;
    localparam int HIT_W       = 10;
    localparam int PAT_LEN_W   = 5;
    localparam int PAT_WORD_W  = 64;
    localparam int PAT_BYTES   = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CASE_FOLD         = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LOW_WORD  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_HIGH_WORD = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_HIT_LIMIT         = 3'd4;

    localparam logic [HIT_W-1:0]  HIT_LIMIT_RESET = 10'd500;
    localparam logic [BYTE_W-1:0] NEWLINE         = 8'h0A;

    // ascii lower-casing when enabled
    function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] b,
                                                    input logic en);
        logic [BYTE_W-1:0] r;
        r = b;
        if (en && (b >= 8'h41) && (b <= 8'h5A))
        begin
            r = b + 8'h20;
        end
        return r;
    endfunction

endpackage

// File: hdl/lgfs_in_if.sv
// Input channel: one file byte per word with an end-of-file flag.
// Depends on lgfs_pkg.
interface lgfs_in_if;
    logic                          valid;
    logic                          ready;
    logic [lgfs_pkg::BYTE_W-1:0]   data_byte;
    logic                          last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// File: hdl/lgfs_out_if.sv
// Output channel: one matching-line report per word.
// Depends on lgfs_pkg.
interface lgfs_out_if #(
    parameter int POS_W = lgfs_pkg::DEF_POSITION_BITS
);
    logic                          valid;
    logic                          ready;
    logic [POS_W-1:0]              line_number;
    logic [POS_W-1:0]              line_offset;
    logic [lgfs_pkg::SHOW_W-1:0]   shown_length;
    logic [lgfs_pkg::HIT_W-1:0]    hit_index;

    modport source (output valid, output line_number, output line_offset,
                    output shown_length, output hit_index, input ready);
    modport sink   (input valid, input line_number, input line_offset,
                    input shown_length, input hit_index, output ready);
endinterface

// File: hdl/line_grep_fixed_string.sv
// A word accepted on the input channel enters the input register; its report, if any,
// goes on to the result register. Throughput: one byte per cycle, set by the
// combinational window compare; input stalls only while the result register is full
// and not taken. Reset: rst_n asynchronous, active low; clears line state, counters and
// the configuration (pattern empty, no folding, hit limit 500).
// Fixed-string line grep top level; depends on lgfs_pkg, lgfs_in_if, lgfs_out_if.
module line_grep_fixed_string #(
    parameter int MAX_PATTERN   = lgfs_pkg::DEF_MAX_PATTERN,
    parameter int POSITION_BITS = lgfs_pkg::DEF_POSITION_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [lgfs_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [lgfs_pkg::CFG_DATA_W-1:0]    cfg_data,
    lgfs_in_if.sink                            in_ch,
    lgfs_out_if.source                         out_ch
);
    import lgfs_pkg::*;

    // shown-length clip, sized to the fixed shown_length field
    localparam int SHOW_LIMIT = DEF_SHOW_LIMIT;

    localparam int POS_W   = POSITION_BITS;
    localparam int LEN_W   = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int WIN_D   = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
    localparam logic [HIT_W-1:0] HIT_MAX = {HIT_W{1'b1}};

    // configuration registers
    logic [PAT_LEN_W-1:0]  pat_len_reg;
    logic                  case_fold_reg;
    logic [PAT_WORD_W-1:0] pat_low_reg;
    logic [PAT_WORD_W-1:0] pat_high_reg;
    logic [HIT_W-1:0]      hit_limit_reg;

    // input register
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;

    // line state
    logic [BYTE_W-1:0] win_reg [WIN_D];
    logic [POS_W-1:0]  bil_reg;
    logic              matched_reg;
    logic [POS_W-1:0]  line_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  start_reg;
    logic [HIT_W-1:0]  hits_reg;

    // result register
    logic              out_valid_reg;
    logic [POS_W-1:0]  out_line_reg;
    logic [POS_W-1:0]  out_offset_reg;
    logic [SHOW_W-1:0] out_shown_reg;
    logic [HIT_W-1:0]  out_hit_reg;

    logic              advance;
    logic [LEN_W-1:0]  len_cap;
    logic [BYTE_W-1:0] pat_arr [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] eq;
    logic              ends_here;
    logic              is_nl;
    logic              line_end;
    logic              matched_now;
    logic              emit;
    logic [POS_W-1:0]  bil_inc;
    logic [POS_W-1:0]  pos_inc;
    logic [POS_W-1:0]  line_inc;
    logic [POS_W-1:0]  shown_full;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_len_reg   <= '0;
            case_fold_reg <= 1'b0;
            pat_low_reg   <= '0;
            pat_high_reg  <= '0;
            hit_limit_reg <= HIT_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PATTERN_LENGTH:    pat_len_reg   <= cfg_data[PAT_LEN_W-1:0];
                CFG_CASE_FOLD:         case_fold_reg <= cfg_data[0];
                CFG_PATTERN_LOW_WORD:  pat_low_reg   <= cfg_data;
                CFG_PATTERN_HIGH_WORD: pat_high_reg  <= cfg_data;
                CFG_HIT_LIMIT:         hit_limit_reg <= cfg_data[HIT_W-1:0];
                default:               ;
            endcase
        end
    end

    // handshake: stage moves when the result register is free or being drained
    assign advance     = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            in_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            in_byte_reg <= in_ch.data_byte;
            in_last_reg <= in_ch.last_byte;
        end
    end

    // pattern bytes, zero beyond the two pattern words
    for (genvar j = 0; j < MAX_PATTERN; j++)
    begin : g_pat
        if (j < PAT_BYTES / 2)
        begin : g_low
            assign pat_arr[j] = pat_low_reg[j*BYTE_W +: BYTE_W];
        end
        else if (j < PAT_BYTES)
        begin : g_high
            assign pat_arr[j] = pat_high_reg[(j-PAT_BYTES/2)*BYTE_W +: BYTE_W];
        end
        else
        begin : g_zero
            assign pat_arr[j] = '0;
        end
    end

    // effective pattern length
    always_comb
    begin
        if (int'(pat_len_reg) > MAX_PATTERN)
        begin
            len_cap = LEN_W'(MAX_PATTERN);
        end
        else
        begin
            len_cap = LEN_W'(pat_len_reg);
        end
    end

    // parallel compare: position k back from the current byte against the
    // pattern byte that must sit there when the pattern ends here
    for (genvar k = 0; k < MAX_PATTERN; k++)
    begin : g_cmp
        logic [BYTE_W-1:0] src;
        logic [IDX_W-1:0]  pidx;
        if (k == 0)
        begin : g_cur
            assign src = in_byte_reg;
        end
        else
        begin : g_win
            assign src = win_reg[k-1];
        end
        assign pidx  = IDX_W'(int'(len_cap) - 1 - k);
        assign eq[k] = (k >= int'(len_cap)) ||
                       (fold_byte(src, case_fold_reg) == fold_byte(pat_arr[pidx], case_fold_reg));
    end

    assign ends_here = (len_cap != '0) &&
                       (((POS_W+1)'(bil_reg) + 1'b1) >= (POS_W+1)'(len_cap)) && (&eq);

    // per-byte next values
    assign is_nl       = (in_byte_reg == NEWLINE);
    assign line_end    = is_nl || in_last_reg;
    assign matched_now = matched_reg || (!is_nl && ends_here);
    assign emit        = line_end && matched_now && (hits_reg < hit_limit_reg);
    assign pos_inc     = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;
    assign line_inc    = (line_reg == POS_MAX) ? line_reg : line_reg + 1'b1;

    always_comb
    begin
        if (is_nl || (bil_reg == POS_MAX))
        begin
            bil_inc = bil_reg;
        end
        else
        begin
            bil_inc = bil_reg + 1'b1;
        end
        if ((POS_W+1)'(bil_inc) > (POS_W+1)'(SHOW_LIMIT))
        begin
            shown_full = POS_W'(SHOW_LIMIT);
        end
        else
        begin
            shown_full = bil_inc;
        end
    end

    // line state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WIN_D; i++)
            begin
                win_reg[i] <= '0;
            end
            bil_reg     <= '0;
            matched_reg <= 1'b0;
            line_reg    <= POS_W'(1);
            pos_reg     <= '0;
            start_reg   <= '0;
            hits_reg    <= '0;
        end
        else if (advance)
        begin
            if (in_last_reg)
            begin
                for (int i = 0; i < WIN_D; i++)
                begin
                    win_reg[i] <= '0;
                end
                bil_reg     <= '0;
                matched_reg <= 1'b0;
                line_reg    <= POS_W'(1);
                pos_reg     <= '0;
                start_reg   <= '0;
                hits_reg    <= '0;
            end
            else
            begin
                pos_reg <= pos_inc;
                if (line_end)
                begin
                    for (int i = 0; i < WIN_D; i++)
                    begin
                        win_reg[i] <= '0;
                    end
                    bil_reg     <= '0;
                    matched_reg <= 1'b0;
                    line_reg    <= line_inc;
                    start_reg   <= pos_inc;
                    if (emit && (hits_reg != HIT_MAX))
                    begin
                        hits_reg <= hits_reg + 1'b1;
                    end
                end
                else
                begin
                    win_reg[0] <= in_byte_reg;
                    for (int i = 1; i < WIN_D; i++)
                    begin
                        win_reg[i] <= win_reg[i-1];
                    end
                    bil_reg     <= bil_inc;
                    matched_reg <= matched_now;
                end
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= emit;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_line_reg   <= line_reg;
            out_offset_reg <= start_reg;
            out_shown_reg  <= SHOW_W'(shown_full);
            out_hit_reg    <= hits_reg;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.line_number  = out_line_reg;
    assign out_ch.line_offset  = out_offset_reg;
    assign out_ch.shown_length = out_shown_reg;
    assign out_ch.hit_index    = out_hit_reg;

endmodule
